@@ sv/level_gauge_digit_overlay_pixels_macros.svh @@
// Assertion helpers shared by the gauge RTL.
// Every check samples on the rising edge of clk and is switched off while rst is high.
`ifndef LEVEL_GAUGE_DIGIT_OVERLAY_PIXELS_MACROS_SVH
`define LEVEL_GAUGE_DIGIT_OVERLAY_PIXELS_MACROS_SVH

`ifndef SYNTHESIS
`define LGAUGE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LGAUGE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LGAUGE_ASSERT_SAME(lbl, ante, cons, msg)
`define LGAUGE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/lgauge_pkg.sv @@
package lgauge_pkg;

  localparam int DEF_FRAME_WIDTH  = 100;
  localparam int DEF_FRAME_HEIGHT = 200;

  localparam int LEVEL_W   = 11;
  localparam int SCALE_W   = 10;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd500;
  localparam logic [SCALE_W-1:0] SHOWN_MAX   = 10'd999;

  localparam int GLYPH_SIZE   = 16;
  localparam int GLYPH_OFFSET = 24;
  localparam int GLYPH_SLOTS  = 3;
  localparam int RED_FULL     = 255;
  localparam logic [7:0] GREEN_ON = 8'd250;

  // Settled display values, derived from the level registers.
  typedef struct packed {
    logic       bar_en;
    logic [7:0] red_val;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } gauge_cfg_t;

  // Font: one 16-bit word per glyph row, leftmost pixel in the MSB.
  localparam logic [15:0] GLYPH_ROM [0:159] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h07F0, 16'h1C18, 16'h381C, 16'h380E, 16'h380E,
    16'h780E, 16'h380E, 16'h380E, 16'h381C, 16'h1C38, 16'h07F0, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h03C0, 16'h0FC0, 16'h01C0, 16'h01C0, 16'h01C0,
    16'h01C0, 16'h01C0, 16'h01C0, 16'h01C0, 16'h01C0, 16'h0FF8, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0FF8, 16'h181C, 16'h380C, 16'h181C, 16'h0038,
    16'h0070, 16'h01C0, 16'h0700, 16'h1C04, 16'h3FFC, 16'h3FFC, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0FF0, 16'h3818, 16'h381C, 16'h0018, 16'h01F0,
    16'h01F8, 16'h001C, 16'h000E, 16'h380C, 16'h381C, 16'h0FF0, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0030, 16'h00F0, 16'h01F0, 16'h0270, 16'h0C70,
    16'h1870, 16'h3070, 16'h3FFE, 16'h0070, 16'h0070, 16'h03FE, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h1FFC, 16'h1800, 16'h1800, 16'h18C0, 16'h1FF8,
    16'h181C, 16'h000C, 16'h180E, 16'h380C, 16'h3818, 16'h0FF0, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h07F8, 16'h0C1C, 16'h1800, 16'h3800, 16'h3FF8,
    16'h3C1C, 16'h380E, 16'h380E, 16'h380E, 16'h1C1C, 16'h07F0, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h1FFE, 16'h380C, 16'h3010, 16'h0020, 16'h0060,
    16'h00C0, 16'h0180, 16'h0380, 16'h0380, 16'h0380, 16'h0380, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0FF8, 16'h380C, 16'h300C, 16'h3C0C, 16'h0FF8,
    16'h0FF0, 16'h383C, 16'h300E, 16'h700E, 16'h381C, 16'h0FF0, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0FF0, 16'h3818, 16'h300C, 16'h700E, 16'h301E,
    16'h383E, 16'h0FEE, 16'h001C, 16'h1818, 16'h3C30, 16'h1FE0, 16'h0000, 16'h0000
  };

  function automatic logic [15:0] glyph_row(input logic [3:0] digit, input logic [3:0] dr);
    logic [15:0] word;
    word = 16'h0000;
    if (digit <= 4'd9) begin
      word = GLYPH_ROM[{digit, dr}];
    end
    return word;
  endfunction

endpackage

@@ sv/lgauge_div.sv @@
module lgauge_div import lgauge_pkg::*; #(
  parameter int NUM_W = 21
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [NUM_W-1:0]   dividend,
  input  logic [SCALE_W-1:0] divisor,
  output logic               busy,
  output logic [NUM_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   work;
  logic [SCALE_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic [SCALE_W:0]   trial;
  logic               take;
  logic [SCALE_W:0]   diff;

  // Restoring division, one quotient bit per cycle, quotient bits shift into work.
  always_comb begin
    trial = {rem, work[NUM_W-1]};
    take  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (go) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      work <= dividend;
      rem  <= '0;
    end else if (cnt != '0) begin
      work <= {work[NUM_W-2:0], take};
      rem  <= take ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
    end
  end

  assign busy     = cnt != '0;
  assign quotient = work;

endmodule

@@ sv/lgauge_pix.sv @@
module lgauge_pix import lgauge_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
  parameter int FILL_W       = $clog2(DEF_FRAME_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [ROW_W-1:0]  row,
  input  logic [COL_W-1:0]  col,
  input  gauge_cfg_t        gcfg,
  input  logic [FILL_W-1:0] filled,
  output logic              out_valid,
  output logic [7:0]        red,
  output logic [7:0]        green
);

  localparam int HW  = $clog2(FRAME_HEIGHT + 1);
  localparam int WW  = $clog2(FRAME_WIDTH + 1);
  localparam int RW  = (HW > ROW_W) ? HW : ROW_W;
  localparam int CW  = (WW > COL_W) ? WW : COL_W;
  localparam int SW  = RW + 1;
  localparam int R0  = FRAME_HEIGHT / 2 - GLYPH_OFFSET;
  localparam int C0  = FRAME_WIDTH / 2 - GLYPH_OFFSET;

  // Stage A: captured coordinates.
  logic             valid_a;
  logic [RW-1:0]    row_a;
  logic [CW-1:0]    col_a;

  // Stage B: frame, bar and glyph window decisions.
  logic             valid_b;
  logic             frame_b;
  logic             bar_b;
  logic             glyph_win_b;
  logic [3:0]       dr_b;
  logic [5:0]       dc_b;

  logic [RW-1:0]    dr_full;
  logic [CW-1:0]    dc_full;
  logic             frame_c;
  logic             bar_c;
  logic             win_c;

  logic [3:0]       digit;
  logic [15:0]      word;
  logic             glyph_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    row_a <= RW'(row);
    col_a <= CW'(col);
  end

  always_comb begin
    dr_full = row_a - RW'(R0);
    dc_full = col_a - CW'(C0);
    frame_c = (row_a < RW'(FRAME_HEIGHT)) && (col_a < CW'(FRAME_WIDTH));
    bar_c   = gcfg.bar_en && ((SW'(row_a) + SW'(filled)) >= SW'(FRAME_HEIGHT));
    win_c   = (row_a >= RW'(R0)) && (dr_full < RW'(GLYPH_SIZE)) &&
              (col_a >= CW'(C0)) && (dc_full < CW'(GLYPH_SLOTS * GLYPH_SIZE));
  end

  always_ff @(posedge clk) begin
    frame_b     <= frame_c;
    bar_b       <= bar_c;
    glyph_win_b <= win_c;
    dr_b        <= dr_full[3:0];
    dc_b        <= dc_full[5:0];
  end

  always_comb begin
    case (dc_b[5:4])
      2'd0:    digit = gcfg.hund;
      2'd1:    digit = gcfg.tens;
      2'd2:    digit = gcfg.units;
      default: digit = 4'd0;
    endcase
    word     = glyph_row(digit, dr_b);
    glyph_on = frame_b && glyph_win_b && word[~dc_b[3:0]];
  end

  always_ff @(posedge clk) begin
    if (glyph_on) begin
      red   <= 8'd0;
      green <= GREEN_ON;
    end else begin
      red   <= (frame_b && bar_b) ? gcfg.red_val : 8'd0;
      green <= 8'd0;
    end
  end

endmodule

@@ sv/level_gauge_digit_overlay_pixels.sv @@
// Each accepted pixel passes the stage A, stage B and output registers, and its colour is on
// the result ports for a single cycle, marked by result_strobe.
// Throughput: one pixel per clock while busy is low, through a three-stage pipeline.
// After a configuration write, and after reset, busy stays high while a bit-serial
// divider works out the bar height and red intensity. Reset is synchronous.
`include "level_gauge_digit_overlay_pixels_macros.svh"

module level_gauge_digit_overlay_pixels import lgauge_pkg::*; #(
  parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ROW_W-1:0]     pixel_row,
  input  logic [COL_W-1:0]     pixel_col,
  output logic                 result_strobe,
  output logic [7:0]           red_level,
  output logic [7:0]           green_level,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data
);

  // Bar height needs enough bits to hold FRAME_HEIGHT itself; both divisions share
  // one dividend width, sized for the larger of level times frame height plus a
  // rounding term and level times full red intensity.
  localparam int HW    = $clog2(FRAME_HEIGHT + 1);
  localparam int RED_W = $clog2(RED_FULL + 1);
  localparam int NUM_W = SCALE_W + ((HW > RED_W) ? HW : RED_W);

  logic [LEVEL_W-1:0] level_value;
  logic [SCALE_W-1:0] full_scale;
  logic [SCALE_W-1:0] level_clamped;
  logic [SCALE_W-1:0] level_clamped_next;

  logic               cfg_write;
  logic               item_take;

  // Recalculation sequencer: the settle1, settle2 and settle3 registers, then the dividers run.
  logic               settle1;
  logic               settle2;
  logic               settle3;
  logic               bar_div_busy;
  logic               red_div_busy;

  logic [NUM_W-1:0]   num_bar;
  logic [NUM_W-1:0]   num_red;
  logic [NUM_W-1:0]   quo_bar;
  logic [NUM_W-1:0]   quo_red;

  // Digit split of the shown value, one register stage per multiply.
  logic [SCALE_W-1:0] shown;
  logic [SCALE_W-1:0] shown_d1;
  logic [3:0]         hund_d1;
  logic [3:0]         hund_d2;
  logic [6:0]         rem_d2;
  logic [3:0]         hund_d3;
  logic [3:0]         tens_d3;
  logic [6:0]         rem_d3;
  logic [3:0]         hund_d4;
  logic [3:0]         tens_d4;
  logic [3:0]         units_d4;
  logic [15:0]        hund_prod;
  logic [14:0]        tens_prod;
  logic [10:0]        hund_back;
  logic [10:0]        rem_wide;
  logic [7:0]         tens_back;

  logic               bar_en;
  gauge_cfg_t         gcfg;

  assign cfg_write = cfg_valid && cfg_ready;
  assign item_take = start && !busy;

  // The configuration port stays closed while the derived values are being rebuilt,
  // so a second write cannot overtake a division that is still in flight.
  assign busy      = settle1 || settle2 || settle3 || bar_div_busy || red_div_busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_value <= '0;
      full_scale  <= SCALE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEVEL: level_value <= cfg_data;
        REG_SCALE: full_scale  <= cfg_data[SCALE_W-1:0];
        default:   ;
      endcase
    end
  end

  // Reset also starts a recalculation, so the reset values are reflected too.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle1 <= 1'b1;
      settle2 <= 1'b0;
      settle3 <= 1'b0;
    end else begin
      settle1 <= cfg_write;
      settle2 <= settle1;
      settle3 <= settle2;
    end
  end

  // A zero full scale or a negative level shows as an empty gauge; a level past
  // full scale is held at full scale.
  always_comb begin
    if (full_scale == '0 || level_value[LEVEL_W-1]) begin
      level_clamped_next = '0;
    end else if (level_value[SCALE_W-1:0] > full_scale) begin
      level_clamped_next = full_scale;
    end else begin
      level_clamped_next = level_value[SCALE_W-1:0];
    end
  end

  // The dividends are registered ahead of the divider start so that the constant
  // multiply and the rounding add are held in registers of their own.
  always_ff @(posedge clk) begin
    level_clamped <= level_clamped_next;
    bar_en        <= level_clamped != '0;
    num_bar       <= NUM_W'(level_clamped) * NUM_W'(FRAME_HEIGHT) + NUM_W'(full_scale) -
                     NUM_W'(1);
    num_red       <= NUM_W'(level_clamped) * NUM_W'(RED_FULL);
  end

  // Bar height is the rounded-up quotient; the red intensity rounds down.
  lgauge_div #(
    .NUM_W (NUM_W)
  ) u_div_bar (
    .clk      (clk),
    .rst      (rst),
    .go       (settle3),
    .dividend (num_bar),
    .divisor  (full_scale),
    .busy     (bar_div_busy),
    .quotient (quo_bar)
  );

  lgauge_div #(
    .NUM_W (NUM_W)
  ) u_div_red (
    .clk      (clk),
    .rst      (rst),
    .go       (settle3),
    .dividend (num_red),
    .divisor  (full_scale),
    .busy     (red_div_busy),
    .quotient (quo_red)
  );

  // The readout tops out at 999 when the full scale allows a larger level.
  // Division by 100 and by 10 uses exact reciprocal multiplies for these ranges.
  always_comb begin
    shown     = (level_clamped > SHOWN_MAX) ? SHOWN_MAX : level_clamped;
    hund_prod = 16'(shown) * 16'd41;
    hund_back = 11'(hund_d1) * 11'd100;
    rem_wide  = 11'(shown_d1) - hund_back;
    tens_prod = 15'(rem_d2) * 15'd205;
    tens_back = 8'(tens_d3) * 8'd10;
  end

  always_ff @(posedge clk) begin
    shown_d1 <= shown;
    hund_d1  <= hund_prod[15:12];
    hund_d2  <= hund_d1;
    rem_d2   <= rem_wide[6:0];
    hund_d3  <= hund_d2;
    tens_d3  <= tens_prod[14:11];
    rem_d3   <= rem_d2;
    hund_d4  <= hund_d3;
    tens_d4  <= tens_d3;
    units_d4 <= 4'(8'(rem_d3) - tens_back);
  end

  // The derived values only settle while busy is high, and no pixel is taken then.
  assign gcfg.bar_en  = bar_en;
  assign gcfg.red_val = quo_red[7:0];
  assign gcfg.hund    = hund_d4;
  assign gcfg.tens    = tens_d4;
  assign gcfg.units   = units_d4;

  lgauge_pix #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .FILL_W       (HW)
  ) u_pix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_take),
    .row       (pixel_row),
    .col       (pixel_col),
    .gcfg      (gcfg),
    .filled    (quo_bar[HW-1:0]),
    .out_valid (result_strobe),
    .red       (red_level),
    .green     (green_level)
  );

  `LGAUGE_ASSERT_SAME(a_item_latency, item_take, ##3 result_strobe, "pixel item result missing")
  `LGAUGE_ASSERT_NEXT(a_cfg_recalc, cfg_write, busy, "configuration write did not raise busy")
  `LGAUGE_ASSERT_SAME(a_colour_excl, result_strobe, !(|red_level && |green_level), "both lit")

endmodule
